>>> rtl/cpkht_pkg.sv
package cpkht_pkg;

    localparam int MAX_BUCKETS = 1024;
    localparam int POOL_NODES  = 1024;
    localparam int KEY_BITS    = 20;
    localparam int BKT_W       = $clog2(MAX_BUCKETS);
    localparam int NODE_W      = $clog2(POOL_NODES);
    localparam int PTR_W       = NODE_W + 1;
    localparam int CNT_W       = 11;
    localparam int HASH_W      = KEY_BITS + 6;
    localparam int KEY_W       = 2 * KEY_BITS;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [19:0] key_first;
        logic [19:0] key_second;
        logic [63:0] payload_theta;
        logic [63:0] payload_phi;
        logic [63:0] payload_pa;
        logic [63:0] payload_pb;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_theta;
        logic [63:0] found_phi;
        logic [63:0] found_pa;
        logic [63:0] found_pb;
        logic [10:0] total_entries;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic mod_start;
        logic head_rd;    // read bucket head
        logic node_rd;    // read node at cur
        logic step;       // prev<=cur, cur<=link
        logic set_cur;    // cur<=head
        logic ins_commit;
        logic del_commit;
        logic res_load;
        logic [1:0] res_status;
        logic res_payload;
        logic clr_wr;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       mod_done;
        logic [1:0] op;
        logic       cur_nil;
        logic       key_hit;
        logic       pool_full;
        logic       clr_last;
    } t_sts;

endpackage

>>> rtl/cpkht_ram.sv
module cpkht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> rtl/cpkht_mod.sv
module cpkht_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cpkht_pkg::HASH_W-1:0]  i_num,
    input  logic [cpkht_pkg::CNT_W-1:0]   i_den,
    output logic                          o_done,
    output logic [cpkht_pkg::BKT_W-1:0]   o_rem
);
    // restoring remainder, two bits per cycle
    localparam int HW = cpkht_pkg::HASH_W;
    localparam int CW = $clog2(HW + 2);
    logic [HW-1:0] r_num, n_num;
    logic [cpkht_pkg::CNT_W:0] r_rem, n_rem;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_busy, n_busy;
    logic [cpkht_pkg::CNT_W:0] t;

    always_comb begin
        n_num = r_num;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        t = '0;
        if (i_start) begin
            n_num = i_num;
            n_rem = '0;
            n_cnt = CW'(HW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            for (int k = 0; k < 2; k++) begin
                if (n_cnt != '0) begin
                    t = {n_rem[cpkht_pkg::CNT_W-1:0], n_num[HW-1]};
                    n_num = {n_num[HW-2:0], 1'b0};
                    if (t >= {1'b0, i_den}) begin
                        t = t - {1'b0, i_den};
                    end
                    n_rem = t;
                    n_cnt = n_cnt - 1'b1;
                end
            end
            if (n_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
    end
    assign o_done = (r_cnt == '0);
    assign o_rem = r_rem[cpkht_pkg::BKT_W-1:0];
endmodule

>>> rtl/cpkht_datapath.sv
module cpkht_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cpkht_pkg::t_cmd             i_cmd,
    output cpkht_pkg::t_sts             o_sts,
    input  cpkht_pkg::t_in_item         i_item,
    input  logic [cpkht_pkg::CNT_W-1:0] i_bucket_count,
    output cpkht_pkg::t_out_item        o_res
);
    localparam int BW = cpkht_pkg::BKT_W;
    localparam int NW = cpkht_pkg::NODE_W;
    localparam int PW = cpkht_pkg::PTR_W;
    localparam int KW = cpkht_pkg::KEY_W;
    localparam int KB = cpkht_pkg::KEY_BITS;

    cpkht_pkg::t_in_item r_item;
    logic [PW-1:0] r_free, n_free;
    logic [PW-1:0] r_fresh;
    logic [cpkht_pkg::CNT_W-1:0] r_total;
    logic [PW-1:0] r_cur, r_prev;
    logic [BW-1:0] r_clr;
    cpkht_pkg::t_out_item r_res;

    logic [KB-1:0] k1, k2;
    logic [KW-1:0] key;
    logic [cpkht_pkg::HASH_W-1:0] hnum;
    logic [cpkht_pkg::CNT_W-1:0] den;
    logic [BW-1:0] bkt;
    logic mod_done;

    assign k1 = r_item.key_first[KB-1:0];
    assign k2 = r_item.key_second[KB-1:0];
    assign key = {k2, k1};
    assign hnum = cpkht_pkg::HASH_W'(k2) * cpkht_pkg::HASH_W'(19)
                + cpkht_pkg::HASH_W'(k1);
    assign den = (i_bucket_count == '0) ? cpkht_pkg::CNT_W'(1) :
                 (i_bucket_count > cpkht_pkg::CNT_W'(cpkht_pkg::MAX_BUCKETS)) ?
                 cpkht_pkg::CNT_W'(cpkht_pkg::MAX_BUCKETS) : i_bucket_count;

    cpkht_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.mod_start),
        .i_num(hnum), .i_den(den), .o_done(mod_done), .o_rem(bkt)
    );

    // memories
    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [PW-1:0] head_wd, head_rd;
    logic          link_we;
    logic [NW-1:0] link_wa;
    logic [PW-1:0] link_wd, link_rd;
    logic          node_we;
    logic [KW-1:0] key_rd;
    logic [255:0]  pay_rd;
    logic [NW-1:0] node_ra;
    logic [NW-1:0] new_node;
    logic [PW-1:0] r_link_cur;

    assign node_ra = r_cur[NW-1:0];
    assign new_node = (r_free != cpkht_pkg::NIL) ? r_free[NW-1:0] : r_fresh[NW-1:0];

    always_comb begin
        head_we = 1'b0;
        head_wa = bkt;
        head_wd = {1'b0, new_node};
        link_we = 1'b0;
        link_wa = new_node;
        link_wd = head_rd;
        node_we = 1'b0;
        if (i_cmd.clr_wr) begin
            head_we = 1'b1;
            head_wa = r_clr;
            head_wd = cpkht_pkg::NIL;
        end else if (i_cmd.ins_commit) begin
            head_we = 1'b1;
            link_we = 1'b1;
            node_we = 1'b1;
        end else if (i_cmd.del_commit) begin
            if (r_prev != cpkht_pkg::NIL) begin
                link_we = 1'b1;
                link_wa = r_prev[NW-1:0];
                link_wd = r_link_cur;
            end else begin
                head_we = 1'b1;
                head_wd = r_link_cur;
            end
        end
    end

    cpkht_ram #(.WIDTH(PW), .DEPTH(cpkht_pkg::MAX_BUCKETS)) u_heads (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_wa), .i_wdata(head_wd),
        .i_raddr(bkt), .o_rdata(head_rd)
    );
    cpkht_ram #(.WIDTH(PW), .DEPTH(cpkht_pkg::POOL_NODES)) u_links (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_wa), .i_wdata(link_wd),
        .i_raddr(i_cmd.del_commit ? r_free[NW-1:0] : node_ra), .o_rdata(link_rd)
    );
    cpkht_ram #(.WIDTH(KW), .DEPTH(cpkht_pkg::POOL_NODES)) u_keys (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(new_node), .i_wdata(key),
        .i_raddr(node_ra), .o_rdata(key_rd)
    );
    cpkht_ram #(.WIDTH(256), .DEPTH(cpkht_pkg::POOL_NODES)) u_pay (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(new_node),
        .i_wdata({r_item.payload_theta, r_item.payload_phi,
                  r_item.payload_pa, r_item.payload_pb}),
        .i_raddr(node_ra), .o_rdata(pay_rd)
    );

    // freed node link: written in the same commit cycle as the unlink
    // The free list is kept in its own RAM, as deep as the node pool, to avoid a second link write.
    logic          fl_we;
    logic [PW-1:0] fl_rd;
    assign fl_we = i_cmd.del_commit;
    cpkht_ram #(.WIDTH(PW), .DEPTH(cpkht_pkg::POOL_NODES)) u_flink (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(r_cur[NW-1:0]), .i_wdata(r_free),
        .i_raddr(r_free[NW-1:0]), .o_rdata(fl_rd)
    );

    always_comb begin
        n_free = r_free;
        if (i_cmd.ins_commit && r_free != cpkht_pkg::NIL) begin
            n_free = fl_rd;
        end else if (i_cmd.del_commit) begin
            n_free = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= cpkht_pkg::NIL;
            r_fresh <= '0;
            r_total <= '0;
            r_clr <= '0;
        end else begin
            r_free <= n_free;
            if (i_cmd.ins_commit) begin
                if (r_free == cpkht_pkg::NIL) begin
                    r_fresh <= r_fresh + 1'b1;
                end
                r_total <= r_total + 1'b1;
            end
            if (i_cmd.del_commit && r_total != '0) begin
                r_total <= r_total - 1'b1;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
        end
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.set_cur) begin
            r_cur <= head_rd;
            r_prev <= cpkht_pkg::NIL;
        end else if (i_cmd.step) begin
            r_prev <= r_cur;
            r_cur <= link_rd;
        end
        if (i_cmd.node_rd) begin
            r_link_cur <= link_rd;
        end
        if (i_cmd.res_load) begin
            r_res.status <= i_cmd.res_status;
            {r_res.found_theta, r_res.found_phi, r_res.found_pa, r_res.found_pb}
                <= i_cmd.res_payload ? pay_rd : 256'd0;
            r_res.total_entries <= r_total;
        end
    end

    assign o_sts.mod_done = mod_done;
    assign o_sts.op = r_item.operation;
    assign o_sts.cur_nil = (r_cur == cpkht_pkg::NIL);
    assign o_sts.key_hit = (key_rd == key);
    assign o_sts.pool_full = (r_free == cpkht_pkg::NIL)
                           && (r_fresh == PW'(cpkht_pkg::POOL_NODES));
    assign o_sts.clr_last = (r_clr == BW'(cpkht_pkg::MAX_BUCKETS - 1));
    assign o_res = r_res;
endmodule

>>> rtl/cpkht_ctrl.sv
module cpkht_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output cpkht_pkg::t_cmd o_cmd,
    input  cpkht_pkg::t_sts i_sts
);
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MOD  = 4'd2;
    localparam logic [3:0] S_HRD  = 4'd3;
    localparam logic [3:0] S_HWT  = 4'd4;
    localparam logic [3:0] S_WALK = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_RES  = 4'd7;
    localparam logic [3:0] S_INS  = 4'd8;
    localparam logic [3:0] S_DEL  = 4'd9;
    localparam logic [3:0] S_STEP = 4'd10;

    logic [3:0] r_state, n_state;
    logic r_ov, n_ov;
    logic [1:0] r_ost;
    logic accept;

    assign o_out_valid = r_ov;
    assign o_in_stall = (r_state != S_IDLE);
    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        n_ov = r_ov && i_out_stall;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_start = 1'b1;
                n_state = S_HRD;
            end
            S_HRD: begin
                if (i_sts.mod_done) begin
                    n_state = S_HWT;
                end
            end
            S_HWT: begin
                if (i_sts.op == cpkht_pkg::OP_INSERT) begin
                    if (i_sts.pool_full) begin
                        o_cmd.res_status = cpkht_pkg::ST_FULL;
                        n_state = S_RES;
                    end else begin
                        n_state = S_INS;
                    end
                end else if (i_sts.op == cpkht_pkg::OP_LOOKUP
                          || i_sts.op == cpkht_pkg::OP_DELETE) begin
                    o_cmd.set_cur = 1'b1;
                    n_state = S_WALK;
                end else begin
                    n_state = S_RES;
                end
            end
            S_WALK: begin
                if (i_sts.cur_nil) begin
                    n_state = S_RES;
                end else begin
                    o_cmd.node_rd = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.node_rd = 1'b1;
                if (i_sts.key_hit) begin
                    n_state = (i_sts.op == cpkht_pkg::OP_DELETE) ? S_DEL : S_RES;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_state = S_WALK;
            end
            S_INS: begin
                o_cmd.ins_commit = 1'b1;
                n_state = S_RES;
            end
            S_DEL: begin
                o_cmd.del_commit = 1'b1;
                n_state = S_RES;
            end
            S_RES: begin
                if (!(r_ov && i_out_stall)) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_status = r_ost;
                    o_cmd.res_payload = (i_sts.op == cpkht_pkg::OP_LOOKUP)
                                     && (r_ost == cpkht_pkg::ST_DONE);
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ov <= 1'b0;
            r_ost <= cpkht_pkg::ST_DONE;
        end else begin
            r_state <= n_state;
            r_ov <= n_ov;
            if (r_state == S_HWT) begin
                if (i_sts.op == cpkht_pkg::OP_INSERT && i_sts.pool_full) begin
                    r_ost <= cpkht_pkg::ST_FULL;
                end else begin
                    r_ost <= cpkht_pkg::ST_DONE;
                end
            end else if (r_state == S_WALK && i_sts.cur_nil) begin
                r_ost <= cpkht_pkg::ST_NOTFOUND;
            end
        end
    end
endmodule

>>> rtl/chained_pair_key_hash_table_core.sv
// channel | direction | handshake
// in      | input     | i_in_valid / o_in_stall, payload i_in_item
// out     | output    | o_out_valid / i_out_stall, payload o_out_item
// cfg     | input     | APB write/read, bucket_count at address 0
// The time from acceptance to an item's result is set by the 2-bit-per-cycle
// modulo unit and by the registered node memory reads, which are repeated for
// every chain node passed over.
// After reset, heads are cleared one bucket a cycle, all 1024 of them, with no item accepted until done.
// A new item is accepted only while idle; a waiting result holds o_out_item
// while i_out_stall is high.
module chained_pair_key_hash_table_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cpkht_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cpkht_pkg::t_out_item  o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [1:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    cpkht_pkg::t_cmd cmd;
    cpkht_pkg::t_sts sts;
    logic [cpkht_pkg::CNT_W-1:0] r_bucket_count;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {21'd0, r_bucket_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= cpkht_pkg::CNT_W'(1024);
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_bucket_count <= pwdata[cpkht_pkg::CNT_W-1:0];
        end
    end

    cpkht_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall), .o_cmd(cmd), .i_sts(sts)
    );
    cpkht_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_item(i_in_item), .i_bucket_count(r_bucket_count), .o_res(o_out_item)
    );

    a_commit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.ins_commit && cmd.del_commit)) else $error("commit overlap");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> o_in_stall) else $error("accept while busy");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid) else $error("result dropped");
endmodule

>>> dv/testbench.sv
module testbench;

    class hash_table_scoreboard;
        logic [39:0]  keys [cpkht_pkg::POOL_NODES];
        logic [255:0] payloads [cpkht_pkg::POOL_NODES];
        int           links [cpkht_pkg::POOL_NODES];
        int           heads [cpkht_pkg::MAX_BUCKETS];
        int           free_list_head;
        int           fresh_used;
        int           entries;
        int           modulus;
        cpkht_pkg::t_out_item pending_results [$];
        int           mismatches;

        function void clear();
            foreach (heads[i]) heads[i] = cpkht_pkg::POOL_NODES;
            foreach (links[i]) links[i] = cpkht_pkg::POOL_NODES;
            free_list_head = cpkht_pkg::POOL_NODES;
            fresh_used = 0;
            entries = 0;
            modulus = 1024;
            mismatches = 0;
        endfunction

        function void set_bucket_count(int value);
            modulus = value & 'h7ff;
        endfunction

        function void note_input(cpkht_pkg::t_in_item it);
            cpkht_pkg::t_out_item res;
            longint unsigned m;
            int b, n, prev, cur, steps;
            logic [39:0] key;
            res = '0;
            m = (modulus == 0) ? 1 : (modulus > cpkht_pkg::MAX_BUCKETS ?
                cpkht_pkg::MAX_BUCKETS : modulus);
            key = {it.key_second, it.key_first};
            b = int'((longint'(it.key_second) * 19 + longint'(it.key_first)) % m);
            res.status = cpkht_pkg::ST_DONE;
            if (it.operation == cpkht_pkg::OP_INSERT) begin
                n = cpkht_pkg::POOL_NODES;
                if (free_list_head < cpkht_pkg::POOL_NODES) begin
                    n = free_list_head;
                    free_list_head = links[n];
                end else if (fresh_used < cpkht_pkg::POOL_NODES) begin
                    n = fresh_used;
                    fresh_used++;
                end
                if (n >= cpkht_pkg::POOL_NODES) begin
                    res.status = cpkht_pkg::ST_FULL;
                end else begin
                    keys[n] = key;
                    payloads[n] = {it.payload_theta, it.payload_phi, it.payload_pa,
                                   it.payload_pb};
                    links[n] = heads[b];
                    heads[b] = n;
                    entries++;
                end
            end else if (it.operation == cpkht_pkg::OP_LOOKUP ||
                         it.operation == cpkht_pkg::OP_DELETE) begin
                prev = cpkht_pkg::POOL_NODES;
                cur = heads[b];
                steps = 0;
                while (cur < cpkht_pkg::POOL_NODES && steps < cpkht_pkg::POOL_NODES &&
                       keys[cur] != key) begin
                    prev = cur;
                    cur = links[cur];
                    steps++;
                end
                if (!(cur < cpkht_pkg::POOL_NODES && steps < cpkht_pkg::POOL_NODES)) begin
                    res.status = cpkht_pkg::ST_NOTFOUND;
                end else if (it.operation == cpkht_pkg::OP_LOOKUP) begin
                    {res.found_theta, res.found_phi, res.found_pa, res.found_pb} =
                        payloads[cur];
                end else begin
                    if (prev < cpkht_pkg::POOL_NODES) links[prev] = links[cur];
                    else heads[b] = links[cur];
                    links[cur] = free_list_head;
                    free_list_head = cur;
                    if (entries > 0) entries--;
                end
            end
            res.total_entries = entries[10:0];
            pending_results.push_back(res);
        endfunction

        function void check_result(cpkht_pkg::t_out_item got);
            cpkht_pkg::t_out_item exp;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp = pending_results.pop_front();
            if (got.status !== exp.status || got.found_theta !== exp.found_theta ||
                got.found_phi !== exp.found_phi || got.found_pa !== exp.found_pa ||
                got.found_pb !== exp.found_pb ||
                got.total_entries !== exp.total_entries) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h got %h", exp, got);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_stall;
    cpkht_pkg::t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_stall = 0;
    cpkht_pkg::t_out_item o_out_item;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    hash_table_scoreboard table_model;
    logic [39:0] used_keys [$];
    bit hold_long = 0;
    bit stim_done = 0;

    chained_pair_key_hash_table_core uut (.*);

    always #10 i_clk = ~i_clk;

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_bucket_count(int value);
        @(negedge i_clk);
        psel = 1; pwrite = 1; paddr = '0; pwdata = value;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
        table_model.set_bucket_count(value);
    endtask

    task automatic send_item(cpkht_pkg::t_in_item it);
        int g;
        g = gap_len();
        repeat (g) @(negedge i_clk);
        i_in_item = it;
        i_in_valid = 1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        table_model.note_input(it);
        @(negedge i_clk);
        i_in_valid = 0;
    endtask

    task automatic drain();
        int t;
        t = 0;
        while (table_model.pending_results.size() != 0 && t < 200000) begin
            @(posedge i_clk);
            t++;
        end
        repeat (4200) @(posedge i_clk);
    endtask

    function automatic cpkht_pkg::t_in_item make_item(logic [1:0] op, logic [19:0] a,
                                                       logic [19:0] b);
        cpkht_pkg::t_in_item it;
        it.operation = op;
        it.key_first = a;
        it.key_second = b;
        it.payload_theta = {$urandom, $urandom};
        it.payload_phi = {$urandom, $urandom};
        it.payload_pa = {$urandom, $urandom};
        it.payload_pb = {$urandom, $urandom};
        return it;
    endfunction

    function automatic cpkht_pkg::t_in_item random_item();
        logic [19:0] a, b;
        int r, k;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        op = (r < 45) ? cpkht_pkg::OP_INSERT : (r < 75) ? cpkht_pkg::OP_LOOKUP :
             (r < 97) ? cpkht_pkg::OP_DELETE : cpkht_pkg::OP_UNUSED;
        if (used_keys.size() > 0 && $urandom_range(0, 99) < 75) begin
            k = $urandom_range(0, used_keys.size() - 1);
            {b, a} = used_keys[k];
        end else begin
            a = (r % 4 == 0) ? 20'($urandom) : 20'($urandom_range(0, 7));
            b = (r % 3 == 0) ? 20'($urandom) : 20'($urandom_range(0, 7));
            if (op == cpkht_pkg::OP_INSERT) used_keys.push_back({b, a});
        end
        return make_item(op, a, b);
    endfunction

    always begin
        int g;
        @(negedge i_clk);
        if (hold_long) begin
            i_out_stall = 1;
            repeat (300) @(negedge i_clk);
            i_out_stall = 0;
            hold_long = 0;
        end else if (!stim_done && $urandom_range(0, 3) == 0) begin
            g = gap_len();
            i_out_stall = 1;
            repeat (g) @(negedge i_clk);
            i_out_stall = 0;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall) table_model.check_result(o_out_item);

    initial begin
        int settings [6];
        cpkht_pkg::t_in_item it;
        table_model = new();
        table_model.clear();
        settings = '{1, 0, 2047, 7, 1024, 1500};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes, all operations, duplicates, unused code
        send_item(make_item(cpkht_pkg::OP_LOOKUP, 0, 0));
        send_item(make_item(cpkht_pkg::OP_DELETE, 0, 0));
        it = make_item(cpkht_pkg::OP_INSERT, 20'hfffff, 20'hfffff);
        it.payload_theta = '1; it.payload_phi = '1; it.payload_pa = '1; it.payload_pb = '1;
        send_item(it);
        it = make_item(cpkht_pkg::OP_INSERT, 0, 0);
        it.payload_theta = '0; it.payload_phi = '0; it.payload_pa = '0; it.payload_pb = '0;
        send_item(it);
        send_item(make_item(cpkht_pkg::OP_INSERT, 0, 0));
        send_item(make_item(cpkht_pkg::OP_LOOKUP, 20'hfffff, 20'hfffff));
        send_item(make_item(cpkht_pkg::OP_LOOKUP, 0, 0));
        send_item(make_item(cpkht_pkg::OP_DELETE, 0, 0));
        send_item(make_item(cpkht_pkg::OP_LOOKUP, 0, 0));
        send_item(make_item(cpkht_pkg::OP_UNUSED, 20'hfffff, 0));
        send_item(make_item(cpkht_pkg::OP_INSERT, 19, 1023));
        send_item(make_item(cpkht_pkg::OP_DELETE, 20'hfffff, 20'hfffff));
        send_item(make_item(cpkht_pkg::OP_LOOKUP, 20'hfffff, 20'hfffff));
        send_item(make_item(cpkht_pkg::OP_INSERT, 20'h55555, 20'haaaaa));
        drain();

        foreach (settings[p]) begin
            write_bucket_count(settings[p]);
            for (int i = 0; i < 70; i++) begin
                if (p == 2 && i == 10) hold_long = 1;
                send_item(random_item());
            end
            drain();
        end

        // fill the pool to reach the full status
        write_bucket_count(1024);
        while (table_model.fresh_used < cpkht_pkg::POOL_NODES ||
               table_model.free_list_head < cpkht_pkg::POOL_NODES)
            send_item(make_item(cpkht_pkg::OP_INSERT, 20'($urandom),
                                20'($urandom_range(0, 15))));
        for (int i = 0; i < 3; i++)
            send_item(make_item(cpkht_pkg::OP_INSERT, 20'($urandom), 20'd3));
        for (int i = 0; i < 20; i++) send_item(random_item());
        stim_done = 1;
        drain();
        if (table_model.mismatches == 0 && table_model.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
